// ===== src/tlew_pkg.sv =====
`default_nettype none
package tlew_pkg;

    localparam int LINE_WIDTH = 40;
    localparam int LEN_W      = $clog2(LINE_WIDTH + 1);
    localparam int ADDR_W     = $clog2(LINE_WIDTH);
    localparam int CNT_W      = 6;
    localparam int WIDE_W     = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int CFG_IDX_W  = 2;

    typedef logic [7:0]        byte_t;
    typedef logic [2:0]        action_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam action_t ACT_ECHO    = 3'd0;
    localparam action_t ACT_RUBOUT  = 3'd1;
    localparam action_t ACT_NEWLINE = 3'd2;
    localparam action_t ACT_BELL    = 3'd3;
    localparam action_t ACT_EOF     = 3'd4;

    localparam cfg_idx_t REG_ERASE      = 2'd0;
    localparam cfg_idx_t REG_WORD_ERASE = 2'd1;
    localparam cfg_idx_t REG_KILL       = 2'd2;
    localparam cfg_idx_t REG_EOF        = 2'd3;

    localparam byte_t ERASE_RESET      = 8'd127;
    localparam byte_t WORD_ERASE_RESET = 8'd23;
    localparam byte_t KILL_RESET       = 8'd21;
    localparam byte_t EOF_RESET        = 8'd4;
    localparam byte_t CHAR_LF          = 8'h0A;

    localparam wide_t RUBOUT_MAX = WIDE_W'(63);
    localparam len_t  LINE_LEN   = LEN_W'(LINE_WIDTH);
    localparam addr_t LAST_ADDR  = ADDR_W'(LINE_WIDTH - 1);

    function automatic logic is_space(input byte_t c);
        return (c inside {[8'h09:8'h0D], 8'h20});
    endfunction

    function automatic logic is_print_byte(input byte_t c);
        return (c inside {[8'h09:8'h0D], [8'h20:8'h7E]});
    endfunction

endpackage
`default_nettype wire

// ===== src/tty_line_editor_word_wrap_core.sv =====
`default_nettype none
// Eof, bell, erase and newline are settled at decode; a plain character, kill or a split at the
// edge goes through a further state, and word-erase and a carried word first scan back through
// the line. A carried word is rubbed out, then copied down with a read and a write per character.
// A new byte is taken only once the last one is through, as s_ready is high only in idle, and
// every result can be held back by the receiver.
// Reset (synchronous, active low) empties the line and restores the control bytes.
module tty_line_editor_word_wrap_core (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire  tlew_pkg::byte_t    s_in_byte,
    output logic                     m_valid,
    input  wire                      m_ready,
    output tlew_pkg::action_t        m_action,
    output tlew_pkg::byte_t          m_out_byte,
    output tlew_pkg::count_t         m_rubout_count,
    output logic                     m_last,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  tlew_pkg::cfg_idx_t cfg_index,
    input  wire  tlew_pkg::byte_t    cfg_data
);
    import tlew_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_EDGE    = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_RUB     = 4'd4;
    localparam logic [3:0] S_WRAP_NL = 4'd5;
    localparam logic [3:0] S_COPY_RD = 4'd6;
    localparam logic [3:0] S_COPY_WR = 4'd7;
    localparam logic [3:0] S_PUT     = 4'd8;

    byte_t line_mem [LINE_WIDTH];
    byte_t rd_data_reg;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    byte_t wr_data;

    logic [3:0] state_reg, state_next;
    byte_t erase_reg, word_erase_reg, kill_reg, eof_reg;
    byte_t c_reg, c_next;
    len_t  len_reg, len_next;
    len_t  pos_reg, pos_next;
    len_t  start_reg, start_next;
    len_t  rem_reg, rem_next;
    addr_t src_reg, src_next;
    addr_t dst_reg, dst_next;
    logic  seen_reg, seen_next;
    logic  wrap_reg, wrap_next;

    logic    m_valid_reg;
    action_t m_action_reg;
    byte_t   m_byte_reg;
    count_t  m_cnt_reg;
    logic    m_last_reg;

    logic    out_free;
    logic    emit;
    action_t e_act;
    byte_t   e_byte;
    count_t  e_cnt;
    logic    e_last;

    len_t  len_m1;
    len_t  pos_m1;
    wide_t rem_wide;
    wide_t part;
    len_t  part_len;
    len_t  scan_start;
    logic  scan_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && (state_reg == S_IDLE);
    assign cfg_ready = aresetn;

    assign m_valid        = m_valid_reg;
    assign m_action       = m_action_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_rubout_count = m_cnt_reg;
    assign m_last         = m_last_reg;

    assign len_m1   = len_reg - 1'b1;
    assign pos_m1   = pos_reg - 1'b1;
    assign rem_wide = WIDE_W'(rem_reg);
    assign part     = (rem_wide > RUBOUT_MAX) ? RUBOUT_MAX : rem_wide;
    assign part_len = LEN_W'(part);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // Backward scan step: data in hand is the entry just below pos_reg
    always_comb begin
        scan_done  = 1'b0;
        scan_start = '0;
        if (pos_reg == '0) begin
            scan_done = 1'b1;
        end else if (is_space(rd_data_reg) && seen_reg) begin
            scan_done  = 1'b1;
            scan_start = pos_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        c_next     = c_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        rem_next   = rem_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        seen_next  = seen_reg;
        wrap_next  = wrap_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = c_reg;
        emit       = 1'b0;
        e_act      = ACT_ECHO;
        e_byte     = '0;
        e_cnt      = '0;
        e_last     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    c_next     = s_in_byte;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (len_reg == '0 && c_reg == eof_reg) begin
                        emit   = 1'b1;
                        e_act  = ACT_EOF;
                        e_last = 1'b1;
                    end else if (c_reg == erase_reg) begin
                        if (len_reg != '0) begin
                            emit     = 1'b1;
                            e_act    = ACT_RUBOUT;
                            e_cnt    = CNT_W'(1);
                            e_last   = 1'b1;
                            len_next = len_m1;
                        end
                    end else if (c_reg == word_erase_reg) begin
                        if (len_reg != '0) begin
                            rd_addr    = len_m1[ADDR_W-1:0];
                            pos_next   = len_reg;
                            seen_next  = 1'b0;
                            wrap_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end else if (c_reg == kill_reg) begin
                        if (len_reg != '0) begin
                            rem_next   = len_reg;
                            len_next   = '0;
                            wrap_next  = 1'b0;
                            state_next = S_RUB;
                        end
                    end else if (!is_print_byte(c_reg)) begin
                        emit   = 1'b1;
                        e_act  = ACT_BELL;
                        e_last = 1'b1;
                    end else if (c_reg == CHAR_LF) begin
                        emit     = 1'b1;
                        e_act    = ACT_NEWLINE;
                        e_last   = 1'b1;
                        len_next = '0;
                    end else if (len_reg >= LINE_LEN) begin
                        rd_addr    = LAST_ADDR;
                        state_next = S_EDGE;
                    end else begin
                        state_next = S_PUT;
                    end
                end
            end
            S_EDGE: begin
                rd_addr = LAST_ADDR;
                if (out_free) begin
                    if (!is_space(c_reg) && !is_space(rd_data_reg)) begin
                        pos_next   = LINE_LEN;
                        seen_next  = 1'b0;
                        wrap_next  = 1'b1;
                        state_next = S_SCAN;
                    end else begin
                        emit       = 1'b1;
                        e_act      = ACT_NEWLINE;
                        e_last     = is_space(c_reg);
                        len_next   = '0;
                        state_next = is_space(c_reg) ? S_IDLE : S_PUT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    if (wrap_reg) begin
                        start_next = scan_start;
                        if (scan_start != '0) begin
                            rem_next   = LINE_LEN - scan_start;
                            state_next = S_RUB;
                        end else begin
                            state_next = S_WRAP_NL;
                        end
                    end else begin
                        rem_next   = len_reg - scan_start;
                        len_next   = scan_start;
                        state_next = S_RUB;
                    end
                end else begin
                    if (!is_space(rd_data_reg)) begin
                        seen_next = 1'b1;
                    end
                    // step down and fetch the next entry below
                    pos_next = pos_m1;
                    rd_addr  = ADDR_W'(pos_m1 - 1'b1);
                end
            end
            S_RUB: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_act    = ACT_RUBOUT;
                    e_cnt    = part[CNT_W-1:0];
                    e_last   = !wrap_reg && (rem_reg == part_len);
                    rem_next = rem_reg - part_len;
                    if (rem_reg == part_len) begin
                        state_next = wrap_reg ? S_WRAP_NL : S_IDLE;
                    end
                end
            end
            S_WRAP_NL: begin
                if (out_free) begin
                    emit  = 1'b1;
                    e_act = ACT_NEWLINE;
                    if (start_reg == '0) begin
                        len_next   = '0;
                        state_next = S_PUT;
                    end else begin
                        src_next   = start_reg[ADDR_W-1:0];
                        dst_next   = '0;
                        state_next = S_COPY_RD;
                    end
                end
            end
            S_COPY_RD: begin
                rd_addr    = src_reg;
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                rd_addr = src_reg;
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                    emit    = 1'b1;
                    e_act   = ACT_ECHO;
                    e_byte  = rd_data_reg;
                    if (src_reg == LAST_ADDR) begin
                        len_next   = LEN_W'(dst_reg) + 1'b1;
                        state_next = S_PUT;
                    end else begin
                        src_next   = src_reg + 1'b1;
                        dst_next   = dst_reg + 1'b1;
                        state_next = S_COPY_RD;
                    end
                end
            end
            S_PUT: begin
                if (out_free) begin
                    if (len_reg < LINE_LEN) begin
                        wr_en    = 1'b1;
                        wr_addr  = len_reg[ADDR_W-1:0];
                        len_next = len_reg + 1'b1;
                    end
                    emit       = 1'b1;
                    e_act      = ACT_ECHO;
                    e_byte     = c_reg;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            m_valid_reg    <= 1'b0;
            erase_reg      <= ERASE_RESET;
            word_erase_reg <= WORD_ERASE_RESET;
            kill_reg       <= KILL_RESET;
            eof_reg        <= EOF_RESET;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ERASE:      erase_reg      <= cfg_data;
                    REG_WORD_ERASE: word_erase_reg <= cfg_data;
                    REG_KILL:       kill_reg       <= cfg_data;
                    REG_EOF:        eof_reg        <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_reg     <= c_next;
        pos_reg   <= pos_next;
        start_reg <= start_next;
        rem_reg   <= rem_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        seen_reg  <= seen_next;
        wrap_reg  <= wrap_next;
        if (emit) begin
            m_action_reg <= e_act;
            m_byte_reg   <= e_byte;
            m_cnt_reg    <= e_cnt;
            m_last_reg   <= e_last;
        end
    end

endmodule
`default_nettype wire

// ===== test/tty_line_editor_word_wrap_core_tb.sv =====
module tty_line_editor_word_wrap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlew_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 3 * LINE_WIDTH + 30;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 5;
    localparam int KEYS_PER_PHASE = 50;
    localparam int NDIR = 26;

    // how a directed row is checked
    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_TYPED = 2'd2;

    typedef struct packed {
        action_t act;
        byte_t   ch;
        count_t  cnt;
        logic    last;
    } echo_t;

    typedef struct packed {
        byte_t      b;
        logic [1:0] how;
        echo_t      res;
    } key_row_t;

    localparam echo_t NO_RES = '0;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    byte_t    s_in_byte;
    logic     m_valid;
    logic     m_ready;
    action_t  m_action;
    byte_t    m_out_byte;
    count_t   m_rubout_count;
    logic     m_last;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    byte_t    cfg_data;

    // line editor state as predicted
    byte_t ln_buf [LINE_WIDTH];
    int    ln_len;
    byte_t r_erase, r_werase, r_kill, r_eof;

    echo_t pend_q [$];
    echo_t echo_q [$];

    int  fails = 0;
    int  keys_typed;
    int  keys_fed;
    int  results_seen = 0;
    int  wraps;
    int  edge_clears;
    int  cycles = 0;
    int  burst_left;
    bit  hold_go;

    key_row_t dir_tab [NDIR] = '{
        '{EOF_RESET,        CHK_TYPED, '{ACT_EOF,     8'h00, 6'd0, 1'b1}},
        '{8'h80,            CHK_TYPED, '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
        '{8'hFF,            CHK_TYPED, '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
        '{8'h00,            CHK_TYPED, '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
        '{ERASE_RESET,      CHK_NONE,  NO_RES},
        '{WORD_ERASE_RESET, CHK_NONE,  NO_RES},
        '{KILL_RESET,       CHK_NONE,  NO_RES},
        '{CHAR_LF,          CHK_TYPED, '{ACT_NEWLINE, 8'h00, 6'd0, 1'b1}},
        '{8'h21,            CHK_TYPED, '{ACT_ECHO,    8'h21, 6'd0, 1'b1}},
        '{8'h7E,            CHK_TYPED, '{ACT_ECHO,    8'h7E, 6'd0, 1'b1}},
        '{EOF_RESET,        CHK_TYPED, '{ACT_BELL,    8'h00, 6'd0, 1'b1}},
        '{8'h20,            CHK_TYPED, '{ACT_ECHO,    8'h20, 6'd0, 1'b1}},
        '{8'h41,            CHK_TYPED, '{ACT_ECHO,    8'h41, 6'd0, 1'b1}},
        '{ERASE_RESET,      CHK_TYPED, '{ACT_RUBOUT,  8'h00, 6'd1, 1'b1}},
        '{8'h09,            CHK_TYPED, '{ACT_ECHO,    8'h09, 6'd0, 1'b1}},
        '{8'h42,            CHK_MODEL, NO_RES},
        '{WORD_ERASE_RESET, CHK_MODEL, NO_RES},
        '{WORD_ERASE_RESET, CHK_MODEL, NO_RES},
        '{8'h20,            CHK_TYPED, '{ACT_ECHO,    8'h20, 6'd0, 1'b1}},
        '{8'h0B,            CHK_TYPED, '{ACT_ECHO,    8'h0B, 6'd0, 1'b1}},
        '{WORD_ERASE_RESET, CHK_MODEL, NO_RES},
        '{8'h43,            CHK_TYPED, '{ACT_ECHO,    8'h43, 6'd0, 1'b1}},
        '{8'h0D,            CHK_TYPED, '{ACT_ECHO,    8'h0D, 6'd0, 1'b1}},
        '{KILL_RESET,       CHK_MODEL, NO_RES},
        '{8'h0C,            CHK_TYPED, '{ACT_ECHO,    8'h0C, 6'd0, 1'b1}},
        '{CHAR_LF,          CHK_TYPED, '{ACT_NEWLINE, 8'h00, 6'd0, 1'b1}}
    };

    // erase, word-erase, kill, eof for each random phase
    byte_t ctl_tab [PHASES][4] = '{
        '{8'h08, 8'h17, 8'h15, 8'h04},
        '{8'h00, 8'hFF, 8'h00, 8'hFF},
        '{8'h61, 8'h61, 8'h62, 8'h20},
        '{8'hFF, 8'h20, 8'h0A, 8'h0A},
        '{ERASE_RESET, WORD_ERASE_RESET, KILL_RESET, EOF_RESET}
    };

    tty_line_editor_word_wrap_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_out_byte     (m_out_byte),
        .m_rubout_count (m_rubout_count),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit is_blank(byte_t c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
    endfunction

    function automatic bit is_visible(byte_t c);
        return (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h20 && c <= 8'h7E);
    endfunction

    function automatic void put(action_t a, byte_t b, int cnt);
        pend_q.push_back('{a, b, count_t'(cnt), 1'b0});
    endfunction

    function automatic void put_rubout(int cnt);
        int part;
        while (cnt > 0) begin
            part = (cnt > 63) ? 63 : cnt;
            put(ACT_RUBOUT, 8'h00, part);
            cnt -= part;
        end
    endfunction

    // index just after the blank that precedes the last word
    function automatic int word_start();
        int  p;
        bit  seen;
        p = ln_len;
        seen = 1'b0;
        while (p > 0) begin
            if (is_blank(ln_buf[p-1])) begin
                if (seen)
                    return p;
            end else begin
                seen = 1'b1;
            end
            p--;
        end
        return 0;
    endfunction

    function automatic void keep_char(byte_t c);
        if (ln_len < LINE_WIDTH) begin
            ln_buf[ln_len] = c;
            ln_len++;
        end
        put(ACT_ECHO, c, 0);
    endfunction

    function automatic void edit_line(byte_t c);
        int st;
        int wl;
        pend_q.delete();
        if (ln_len == 0 && c == r_eof) begin
            put(ACT_EOF, 8'h00, 0);
        end else if (c == r_erase) begin
            if (ln_len > 0) begin
                put(ACT_RUBOUT, 8'h00, 1);
                ln_len--;
            end
        end else if (c == r_werase) begin
            if (ln_len > 0) begin
                st = word_start();
                put_rubout(ln_len - st);
                ln_len = st;
            end
        end else if (c == r_kill) begin
            put_rubout(ln_len);
            ln_len = 0;
        end else if (!is_visible(c)) begin
            put(ACT_BELL, 8'h00, 0);
        end else if (c == CHAR_LF) begin
            put(ACT_NEWLINE, 8'h00, 0);
            ln_len = 0;
        end else if (ln_len >= LINE_WIDTH) begin
            if (!is_blank(c) && !is_blank(ln_buf[LINE_WIDTH-1])) begin
                st = word_start();
                wl = LINE_WIDTH - st;
                wraps++;
                if (st > 0) begin
                    // carry the partial word down to the new line
                    put_rubout(wl);
                    put(ACT_NEWLINE, 8'h00, 0);
                    for (int i = 0; i < wl; i++) begin
                        ln_buf[i] = ln_buf[st+i];
                        put(ACT_ECHO, ln_buf[i], 0);
                    end
                    ln_len = wl;
                end else begin
                    put(ACT_NEWLINE, 8'h00, 0);
                    ln_len = 0;
                end
                keep_char(c);
            end else begin
                edge_clears++;
                put(ACT_NEWLINE, 8'h00, 0);
                ln_len = 0;
                if (!is_blank(c))
                    keep_char(c);
            end
        end else begin
            keep_char(c);
        end
        if (pend_q.size() > 0)
            pend_q[pend_q.size()-1].last = 1'b1;
    endfunction

    task automatic type_key(input byte_t b, input logic [1:0] how, input echo_t res);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        keys_typed++;
        edit_line(b);
        if (pend_q.size() > 0)
            keys_fed++;
        if (how == CHK_TYPED)
            echo_q.push_back(res);
        else if (how == CHK_MODEL)
            foreach (pend_q[i]) echo_q.push_back(pend_q[i]);
    endtask

    task automatic key(input byte_t b);
        type_key(b, CHK_MODEL, NO_RES);
    endtask

    // wait for every expected result, then let any silent work finish
    task automatic settle();
        s_valid <= 1'b0;
        while (echo_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_controls(input int ph);
        cfg_idx_t idx_list [4];
        idx_list = '{REG_ERASE, REG_WORD_ERASE, REG_KILL, REG_EOF};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= ctl_tab[ph][i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx_list[i])
                REG_ERASE:      r_erase  = ctl_tab[ph][i];
                REG_WORD_ERASE: r_werase = ctl_tab[ph][i];
                REG_KILL:       r_kill   = ctl_tab[ph][i];
                REG_EOF:        r_eof    = ctl_tab[ph][i];
                default:        ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic byte_t pick_letter();
        return byte_t'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic byte_t pick_blank();
        case ($urandom_range(0, 7))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    task automatic type_stretch();
        int kind;
        int n;
        int wl;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // a few words with blanks between them
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                wl = $urandom_range(1, 10);
                for (int j = 0; j < wl; j++) key(pick_letter());
                key(pick_blank());
                if ($urandom_range(0, 3) == 0)
                    key(pick_blank());
            end
        end else if (kind < 53) begin
            // one long word, often wider than the line
            n = $urandom_range(30, 45);
            for (int i = 0; i < n; i++) key(pick_letter());
        end else if (kind < 61) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) key(pick_blank());
            key(r_werase);
        end else if (kind < 71) begin
            case ($urandom_range(0, 2))
                0: key(r_erase);
                1: key(r_werase);
                default: key(r_kill);
            endcase
        end else if (kind < 81) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) key(byte_t'($urandom_range(0, 255)));
        end else if (kind < 88) begin
            key(($urandom_range(0, 1) == 0) ? CHAR_LF : r_eof);
        end else begin
            // fill to one short of the edge, then probe the edge
            while (ln_len < LINE_WIDTH - 1)
                key(($urandom_range(0, 5) == 0) ? pick_blank() : pick_letter());
            key(($urandom_range(0, 1) == 0) ? pick_blank() : pick_letter());
            key(($urandom_range(0, 1) == 0) ? pick_blank() : pick_letter());
        end
    endtask

    // receiver: changing stall patterns, one long hold-off on request
    initial begin
        int          mode;
        int          left;
        logic [31:0] pat;
        bit          held;
        m_ready = 1'b0;
        mode = 0;
        left = 0;
        pat = '0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    pat  = $urandom;
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: begin
                        m_ready <= pat[0];
                        pat = {pat[0], pat[31:1]};
                    end
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        echo_t want;
        echo_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_action, m_out_byte, m_rubout_count, m_last};
            results_seen++;
            if (echo_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected result action %0d byte %02h count %0d last %b",
                         $time, got.act, got.ch, got.cnt, got.last);
            end else begin
                want = echo_q.pop_front();
                if (got.act !== want.act || got.ch !== want.ch ||
                    got.cnt !== want.cnt || got.last !== want.last) begin
                    fails++;
                    $display("%0t: mismatch, expected action %0d byte %02h count %0d last %b",
                             $time, want.act, want.ch, want.cnt, want.last);
                    $display("%0t:           got action %0d byte %02h count %0d last %b",
                             $time, got.act, got.ch, got.cnt, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d results still due",
                     $time, cycles, echo_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int stop_at;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_in_byte  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        keys_typed = 0;
        keys_fed   = 0;
        wraps      = 0;
        edge_clears = 0;
        burst_left = 0;
        hold_go    = 1'b0;
        ln_len     = 0;
        r_erase    = ERASE_RESET;
        r_werase   = WORD_ERASE_RESET;
        r_kill     = KILL_RESET;
        r_eof      = EOF_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++)
            type_key(dir_tab[i].b, dir_tab[i].how, dir_tab[i].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            set_controls(ph);
            if (ph == 0)
                hold_go = 1'b1;
            stop_at = keys_fed + KEYS_PER_PHASE;
            while (keys_fed < stop_at)
                type_stretch();
        end

        settle();
        $display("typed %0d bytes over %0d control settings, %0d results checked",
                 keys_typed, PHASES + 1, results_seen);
        $display("edge handling: %0d words carried or lines split, %0d lines cleared",
                 wraps, edge_clears);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", fails);
            $display("FAIL");
        end
        $finish;
    end

endmodule
